/* rtl/tllpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllpp_pkg
// Codes and prefix constants for the tagged list length-prefix parser.
// ----------------------------------------------------------------------------
package tllpp_pkg;

    // Byte classification codes
    localparam logic [1:0] KIND_COUNT  = 2'd0;
    localparam logic [1:0] KIND_TAG    = 2'd1;
    localparam logic [1:0] KIND_PREFIX = 2'd2;
    localparam logic [1:0] KIND_DATA   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_PFX   = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    // First prefix byte ranges
    localparam logic [7:0] PFX_ONE_MAX    = 8'd192;
    localparam logic [7:0] PFX_TWO_MAX    = 8'd240;
    localparam logic [7:0] PFX_THREE_MAX  = 8'd254;
    localparam logic [7:0] PFX_TWO_BASE   = 8'd193;
    localparam logic [7:0] PFX_THREE_BASE = 8'd241;

    // Length offsets of the two- and three-byte forms
    localparam logic [19:0] LEN_TWO_OFFSET   = 20'd193;
    localparam logic [19:0] LEN_THREE_OFFSET = 20'd12481;

    localparam int unsigned LEN_W   = 20;
    localparam int unsigned TOTAL_W = 28;

endpackage

/* rtl/tagged_list_length_prefix_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_list_length_prefix_parser_unit
// Byte-at-a-time parser for a counted list of tag / length-prefix / data
// elements, echoing every byte with its kind and element context.
// ----------------------------------------------------------------------------
// Throughput is one byte transaction per clock while results are drained: the
// parse state and the input byte feed a short block of compare/add logic
// that loads the result register directly, so the only stage is that result
// register. The input side stays ready while the result register is empty
// or is being drained in the same cycle, so back-to-back bytes flow without
// bubbles. A list starts with a count byte; each element is a tag byte, a
// length prefix of one to three bytes (first byte 0..192 is the length,
// 193..240 and 241..254 open the two- and three-byte forms, 255 is an error),
// then the data bytes. After a completed list, a bad prefix byte or a buffer
// end that arrives before the list completes, the next byte is taken as a
// new count byte. There is no configuration and no startup sweep.
// ----------------------------------------------------------------------------
module tagged_list_length_prefix_parser_unit
    import tllpp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_stream_byte,
    input  logic                 s_buffer_end,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_byte_kind,
    output logic [7:0]           m_byte_value,
    output logic [7:0]           m_element_tag,
    output logic [7:0]           m_element_index,
    output logic [LEN_W-1:0]     m_element_length,
    output logic                 m_element_last,
    output logic                 m_list_done,
    output logic [TOTAL_W-1:0]   m_list_bytes,
    output logic [1:0]           m_error_code
);

    // Parse phase: what the next byte is expected to be
    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,    // list element count
        PH_TAG   = 3'd1,    // element tag
        PH_PFX   = 3'd2,    // first prefix byte
        PH_P2B   = 3'd3,    // second byte of two-byte form
        PH_P3B   = 3'd4,    // second byte of three-byte form
        PH_P3C   = 3'd5,    // third byte of three-byte form
        PH_DATA  = 3'd6     // data bytes
    } phase_t;

    // Parse state
    phase_t               phase_reg,         phase_next;
    logic [7:0]           elements_left_reg, elements_left_next;
    logic [7:0]           counter_reg,       counter_next;
    logic [7:0]           tag_reg,           tag_next;
    logic [7:0]           pfx_first_reg,     pfx_first_next;
    logic [7:0]           pfx_second_reg,    pfx_second_next;
    logic [LEN_W-1:0]     data_left_reg,     data_left_next;
    logic [LEN_W-1:0]     decoded_reg,       decoded_next;
    logic [TOTAL_W-1:0]   total_reg,         total_next;

    // Result register
    logic                 m_valid_reg;
    logic [1:0]           m_kind_reg,   kind_next;
    logic [7:0]           m_value_reg;
    logic [7:0]           m_tag_reg,    tag_out_next;
    logic [7:0]           m_index_reg,  index_out_next;
    logic [LEN_W-1:0]     m_length_reg, length_out_next;
    logic                 m_last_reg,   last_next;
    logic                 m_done_reg,   done_next;
    logic [TOTAL_W-1:0]   m_bytes_reg;
    logic [1:0]           m_err_reg,    err_next;

    logic                 have_len;
    logic                 s_fire;
    logic [7:0]           pfx_off_two;
    logic [7:0]           pfx_off_three;
    logic [LEN_W-1:0]     data_dec;

    // Output register frees up whenever it is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Offsets of the first prefix byte into its range; only the low bits
    // carry weight in the decoded length
    assign pfx_off_two   = pfx_first_reg - PFX_TWO_BASE;
    assign pfx_off_three = pfx_first_reg - PFX_THREE_BASE;
    assign data_dec      = data_left_reg - LEN_W'(1);

    // ------------------------------------------------------------------
    // Next-state and result logic for one byte
    // ------------------------------------------------------------------
    always_comb begin
        phase_next         = phase_reg;
        elements_left_next = elements_left_reg;
        counter_next       = counter_reg;
        tag_next           = tag_reg;
        pfx_first_next     = pfx_first_reg;
        pfx_second_next    = pfx_second_reg;
        data_left_next     = data_left_reg;
        decoded_next       = decoded_reg;
        total_next         = total_reg + TOTAL_W'(1);

        kind_next          = KIND_COUNT;
        tag_out_next       = tag_reg;
        index_out_next     = counter_reg;
        length_out_next    = '0;
        last_next          = 1'b0;
        done_next          = 1'b0;
        err_next           = ERR_NONE;
        have_len           = 1'b0;

        unique case (phase_reg)
            PH_TAG: begin
                kind_next    = KIND_TAG;
                tag_next     = s_stream_byte;
                tag_out_next = s_stream_byte;
                decoded_next = '0;
                phase_next   = PH_PFX;
            end
            PH_PFX: begin
                kind_next = KIND_PREFIX;
                if (s_stream_byte <= PFX_ONE_MAX) begin
                    decoded_next = {12'd0, s_stream_byte};
                    have_len     = 1'b1;
                end else if (s_stream_byte <= PFX_THREE_MAX) begin
                    pfx_first_next = s_stream_byte;
                    phase_next     = (s_stream_byte <= PFX_TWO_MAX) ? PH_P2B : PH_P3B;
                end else begin
                    err_next = ERR_BAD_PFX;
                end
            end
            PH_P2B: begin
                kind_next    = KIND_PREFIX;
                decoded_next = LEN_TWO_OFFSET + {6'd0, pfx_off_two[5:0], s_stream_byte};
                have_len     = 1'b1;
            end
            PH_P3B: begin
                kind_next       = KIND_PREFIX;
                pfx_second_next = s_stream_byte;
                phase_next      = PH_P3C;
            end
            PH_P3C: begin
                // high nibble weighs 65536; the sum wraps at 20 bits
                kind_next    = KIND_PREFIX;
                decoded_next = LEN_THREE_OFFSET
                             + {pfx_off_three[3:0], pfx_second_reg, s_stream_byte};
                have_len     = 1'b1;
            end
            PH_DATA: begin
                kind_next       = KIND_DATA;
                length_out_next = decoded_reg;
                data_left_next  = data_dec;
                last_next       = (data_dec == '0);
            end
            default: begin
                // count byte; the unused phase code lands here too
                kind_next          = KIND_COUNT;
                total_next         = TOTAL_W'(1);
                elements_left_next = s_stream_byte;
                counter_next       = '0;
                tag_next           = '0;
                decoded_next       = '0;
                data_left_next     = '0;
                tag_out_next       = '0;
                index_out_next     = '0;
                if (s_stream_byte == 8'd0) begin
                    done_next  = 1'b1;
                    phase_next = PH_COUNT;
                end else begin
                    phase_next = PH_TAG;
                end
            end
        endcase

        // Last prefix byte: zero length closes the element right away
        if (have_len) begin
            length_out_next = decoded_next;
            if (decoded_next == '0) begin
                last_next = 1'b1;
            end else begin
                data_left_next = decoded_next;
                phase_next     = PH_DATA;
            end
        end

        // Element complete (never on a count byte)
        if (last_next) begin
            elements_left_next = elements_left_reg - 8'd1;
            if (elements_left_next == 8'd0) begin
                done_next  = 1'b1;
                phase_next = PH_COUNT;
            end else begin
                counter_next = counter_reg + 8'd1;
                phase_next   = PH_TAG;
            end
        end

        // Bad prefix wins over a buffer end
        if (err_next != ERR_NONE) begin
            phase_next = PH_COUNT;
        end else if (s_buffer_end && !done_next) begin
            err_next   = ERR_TRUNCATED;
            phase_next = PH_COUNT;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_COUNT;
            elements_left_reg <= '0;
            counter_reg       <= '0;
            tag_reg           <= '0;
            pfx_first_reg     <= '0;
            pfx_second_reg    <= '0;
            data_left_reg     <= '0;
            decoded_reg       <= '0;
            total_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg         <= phase_next;
                elements_left_reg <= elements_left_next;
                counter_reg       <= counter_next;
                tag_reg           <= tag_next;
                pfx_first_reg     <= pfx_first_next;
                pfx_second_reg    <= pfx_second_next;
                data_left_reg     <= data_left_next;
                decoded_reg       <= decoded_next;
                total_reg         <= total_next;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: loaded on each accepted transaction, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_kind_reg   <= kind_next;
            m_value_reg  <= s_stream_byte;
            m_tag_reg    <= tag_out_next;
            m_index_reg  <= index_out_next;
            m_length_reg <= length_out_next;
            m_last_reg   <= last_next;
            m_done_reg   <= done_next;
            m_bytes_reg  <= done_next ? total_next : '0;
            m_err_reg    <= err_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_byte_kind      = m_kind_reg;
    assign m_byte_value     = m_value_reg;
    assign m_element_tag    = m_tag_reg;
    assign m_element_index  = m_index_reg;
    assign m_element_length = m_length_reg;
    assign m_element_last   = m_last_reg;
    assign m_list_done      = m_done_reg;
    assign m_list_bytes     = m_bytes_reg;
    assign m_error_code     = m_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A list ends either on an empty count byte or on an element's last byte
    a_done_src: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> (m_last_reg || m_kind_reg == KIND_COUNT))
        else $error("list_done without a completing byte");

    // Errors and completion are exclusive
    a_err_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_err_reg != ERR_NONE |-> !m_done_reg)
        else $error("error flagged on a completing byte");

    // After an error or a finished list the parser waits for a count byte
    a_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (err_next != ERR_NONE || done_next) |=> phase_reg == PH_COUNT)
        else $error("parser did not return to count phase");

    // Count and tag bytes carry no decoded length
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_kind_reg == KIND_COUNT || m_kind_reg == KIND_TAG)
        |-> m_length_reg == '0)
        else $error("element_length set on count or tag byte");

    // Data phase always has bytes left to take
    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> data_left_reg != '0)
        else $error("data phase with zero bytes left");

endmodule

/* sim/tllpp_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllpp_stream_checker
// Watches both channels of the tagged list parser, predicts the echo of
// every accepted byte and compares it with the returned transactions in order.
// ----------------------------------------------------------------------------
module tllpp_stream_checker
    import tllpp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [7:0]           s_stream_byte,
    input  logic                 s_buffer_end,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [1:0]           m_byte_kind,
    input  logic [7:0]           m_byte_value,
    input  logic [7:0]           m_element_tag,
    input  logic [7:0]           m_element_index,
    input  logic [LEN_W-1:0]     m_element_length,
    input  logic                 m_element_last,
    input  logic                 m_list_done,
    input  logic [TOTAL_W-1:0]   m_list_bytes,
    input  logic [1:0]           m_error_code,

    output int                   fail_count,
    output int                   outstanding
);

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_TAG,
        PH_PREFIX,
        PH_TWO_LOW,
        PH_THREE_MID,
        PH_THREE_LOW,
        PH_DATA
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         value;
        logic [7:0]         tag;
        logic [7:0]         index;
        logic [LEN_W-1:0]   length;
        logic               last;
        logic               done;
        logic [TOTAL_W-1:0] total;
        logic [1:0]         err;
    } byte_echo_t;

    parse_phase_t       phase;
    logic [7:0]         elems_left;
    logic [7:0]         elem_idx;
    logic [7:0]         cur_tag;
    logic [7:0]         pfx_hi;
    logic [7:0]         pfx_mid;
    logic [LEN_W-1:0]   data_left;
    logic [LEN_W-1:0]   dec_len;
    logic [TOTAL_W-1:0] total;

    byte_echo_t         predicted_echoes[$];
    int                 mismatches = 0;

    assign fail_count = mismatches;

    function automatic byte_echo_t decode_byte(input logic [7:0] b, input logic buf_end);
        byte_echo_t r;
        logic       have_len;
        logic [7:0] hi_off;
        r        = '0;
        r.value  = b;
        r.tag    = cur_tag;
        r.index  = elem_idx;
        r.kind   = KIND_COUNT;
        r.err    = ERR_NONE;
        have_len = 1'b0;
        total    = total + 1'b1;
        case (phase)
            PH_TAG: begin
                r.kind  = KIND_TAG;
                cur_tag = b;
                r.tag   = b;
                dec_len = '0;
                phase   = PH_PREFIX;
            end
            PH_PREFIX: begin
                r.kind = KIND_PREFIX;
                if (b <= PFX_ONE_MAX) begin
                    dec_len  = LEN_W'(b);
                    have_len = 1'b1;
                end else if (b <= PFX_THREE_MAX) begin
                    pfx_hi = b;
                    phase  = (b <= PFX_TWO_MAX) ? PH_TWO_LOW : PH_THREE_MID;
                end else begin
                    r.err = ERR_BAD_PFX;
                end
            end
            PH_TWO_LOW: begin
                r.kind   = KIND_PREFIX;
                hi_off   = pfx_hi - PFX_TWO_BASE;
                dec_len  = LEN_TWO_OFFSET + {6'd0, hi_off[5:0], b};
                have_len = 1'b1;
            end
            PH_THREE_MID: begin
                r.kind  = KIND_PREFIX;
                pfx_mid = b;
                phase   = PH_THREE_LOW;
            end
            PH_THREE_LOW: begin
                r.kind   = KIND_PREFIX;
                hi_off   = pfx_hi - PFX_THREE_BASE;
                dec_len  = LEN_THREE_OFFSET + {hi_off[3:0], pfx_mid, b};
                have_len = 1'b1;
            end
            PH_DATA: begin
                r.kind    = KIND_DATA;
                r.length  = dec_len;
                data_left = data_left - 1'b1;
                if (data_left == '0) r.last = 1'b1;
            end
            default: begin
                // count byte; also where an unused phase code lands
                r.kind     = KIND_COUNT;
                total      = TOTAL_W'(1);
                elems_left = b;
                elem_idx   = '0;
                cur_tag    = '0;
                dec_len    = '0;
                data_left  = '0;
                r.tag      = '0;
                r.index    = '0;
                if (b == 8'd0) begin
                    r.done = 1'b1;
                    phase  = PH_COUNT;
                end else begin
                    phase = PH_TAG;
                end
            end
        endcase

        if (have_len) begin
            r.length = dec_len;
            if (dec_len == '0) begin
                r.last = 1'b1;
            end else begin
                data_left = dec_len;
                phase     = PH_DATA;
            end
        end

        if (r.last) begin
            elems_left = elems_left - 1'b1;
            if (elems_left == 8'd0) begin
                r.done = 1'b1;
                phase  = PH_COUNT;
            end else begin
                elem_idx = elem_idx + 1'b1;
                phase    = PH_TAG;
            end
        end

        // a bad prefix wins over a buffer end on the same byte
        if (r.err != ERR_NONE) begin
            phase = PH_COUNT;
        end else if (buf_end && !r.done) begin
            r.err = ERR_TRUNCATED;
            phase = PH_COUNT;
        end

        r.total = r.done ? total : '0;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        byte_echo_t got;
        byte_echo_t want;
        if (!aresetn) begin
            predicted_echoes.delete();
            phase       = PH_COUNT;
            elems_left  = '0;
            elem_idx    = '0;
            cur_tag     = '0;
            pfx_hi      = '0;
            pfx_mid     = '0;
            data_left   = '0;
            dec_len     = '0;
            total       = '0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_byte_kind, m_byte_value, m_element_tag, m_element_index,
                       m_element_length, m_element_last, m_list_done, m_list_bytes,
                       m_error_code};
                if (predicted_echoes.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result transaction with nothing expected, value %02h",
                                 $time, m_byte_value);
                    mismatches++;
                end else begin
                    want = predicted_echoes.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch (exp/act) kind %0d/%0d value %02h/%02h",
                                     $time, want.kind, got.kind, want.value, got.value);
                            $display("  tag %02h/%02h index %0d/%0d length %0d/%0d",
                                     want.tag, got.tag, want.index, got.index,
                                     want.length, got.length);
                            $display("  last %0b/%0b done %0b/%0b bytes %0d/%0d err %0d/%0d",
                                     want.last, got.last, want.done, got.done,
                                     want.total, got.total, want.err, got.err);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                predicted_echoes.insert(predicted_echoes.size(),
                                        decode_byte(s_stream_byte, s_buffer_end));
            outstanding <= predicted_echoes.size();
        end
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tagged list length-prefix parser: directed
// corner lists, then random well-formed, truncated and corrupted lists with
// random idling on both channels; checking is done by tllpp_stream_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import tllpp_pkg::*;

    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT  = 400000;
    // random part stops once this many bytes have gone in overall
    localparam int RANDOM_ITEMS = 750;
    // length of the one long receiver hold-off
    localparam int HOLD_CYCLES  = 300;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_stream_byte = 8'd0;
    logic                 s_buffer_end  = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [1:0]           m_byte_kind;
    logic [7:0]           m_byte_value;
    logic [7:0]           m_element_tag;
    logic [7:0]           m_element_index;
    logic [LEN_W-1:0]     m_element_length;
    logic                 m_element_last;
    logic                 m_list_done;
    logic [TOTAL_W-1:0]   m_list_bytes;
    logic [1:0]           m_error_code;

    int  fail_count;
    int  outstanding;
    int  cycle_count = 0;
    int  sent_items  = 0;
    bit  idle_on     = 1'b0;    // random idling allowed on both sides
    bit  hold_req    = 1'b0;    // ask the receiver for its long hold-off

    // list builder state: byte position inside the current list, the position
    // where buffer_end cuts it short (-1 for none), and whether it was cut
    int  list_pos;
    int  list_cut;
    bit  list_stop;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    tagged_list_length_prefix_parser_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stream_byte    (s_stream_byte),
        .s_buffer_end     (s_buffer_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_kind      (m_byte_kind),
        .m_byte_value     (m_byte_value),
        .m_element_tag    (m_element_tag),
        .m_element_index  (m_element_index),
        .m_element_length (m_element_length),
        .m_element_last   (m_element_last),
        .m_list_done      (m_list_done),
        .m_list_bytes     (m_list_bytes),
        .m_error_code     (m_error_code)
    );

    tllpp_stream_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stream_byte    (s_stream_byte),
        .s_buffer_end     (s_buffer_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_kind      (m_byte_kind),
        .m_byte_value     (m_byte_value),
        .m_element_tag    (m_element_tag),
        .m_element_index  (m_element_index),
        .m_element_length (m_element_length),
        .m_element_last   (m_element_last),
        .m_list_done      (m_list_done),
        .m_list_bytes     (m_list_bytes),
        .m_error_code     (m_error_code),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // Offer one byte and return at the edge where the transaction happens.
    // An optional idle burst goes first; when there is none, valid simply
    // stays high and only the payload changes at the acceptance edge.
    task automatic send_byte(input logic [7:0] b, input logic e);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        s_buffer_end  <= e;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sent_items++;
    endtask

    // One byte of a list under construction. buffer_end goes high when the
    // caller asks for it or at the chosen cut point; after that the rest of
    // the list is dropped, since the block is back to expecting a count byte.
    task automatic put_byte(input logic [7:0] b, input bit e_req);
        bit e;
        if (!list_stop) begin
            e = e_req || (list_pos == list_cut);
            send_byte(b, e);
            list_pos++;
            if (e) list_stop = 1'b1;
        end
    endtask

    // Build and send a list of n_elem elements. A rough list may be cut by
    // an early buffer end, carry a 0xFF prefix byte, or open a long two- or
    // three-byte length form that is cut at most three data bytes in. With
    // empty_only every element has a zero length (tag plus one prefix byte).
    task automatic send_list(input int n_elem, input bit rough, input bit empty_only);
        int         form;
        int         len;
        int         n_data;
        bit         last_el;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        list_pos  = 0;
        list_stop = 1'b0;
        list_cut  = (rough && $urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : -1;
        put_byte(8'(n_elem), n_elem == 0 && $urandom_range(0, 1) == 1);
        for (int k = 0; k < n_elem && !list_stop; k++) begin
            last_el = (k == n_elem - 1);
            put_byte(8'($urandom), 1'b0);
            form = empty_only ? 0 : $urandom_range(0, 99);
            if (empty_only) begin
                put_byte(8'd0, last_el && $urandom_range(0, 1) == 1);
            end else if (rough && form < 5) begin
                // bad prefix byte, sometimes together with a buffer end
                put_byte(8'hFF, $urandom_range(0, 1) == 1);
                list_stop = 1'b1;
            end else if (rough && form >= 94) begin
                // long length form, always cut short
                b1     = 8'($urandom_range(PFX_TWO_BASE, PFX_THREE_MAX));
                b2     = 8'($urandom);
                b3     = 8'($urandom);
                n_data = $urandom_range(0, 3);
                put_byte(b1, 1'b0);
                if (b1 > PFX_TWO_MAX) put_byte(b2, 1'b0);
                put_byte((b1 > PFX_TWO_MAX) ? b3 : b2, n_data == 0);
                for (int d = 0; d < n_data; d++)
                    put_byte(8'($urandom), d == n_data - 1);
                list_stop = 1'b1;
            end else begin
                if (form < 60)       len = $urandom_range(0, 6);
                else if (form < 88)  len = $urandom_range(7, 40);
                else if (form < 90)  len = PFX_ONE_MAX;
                else                 len = LEN_TWO_OFFSET + $urandom_range(0, 40);
                if (len > PFX_ONE_MAX) begin
                    put_byte(PFX_TWO_BASE, 1'b0);
                    put_byte(8'(len - LEN_TWO_OFFSET),
                             1'b0);
                end else begin
                    put_byte(8'(len), last_el && len == 0 && $urandom_range(0, 1) == 1);
                end
                for (int d = 0; d < len; d++)
                    put_byte(8'($urandom),
                             last_el && d == len - 1 && $urandom_range(0, 1) == 1);
            end
        end
    endtask

    // Receiver: random ready bursts, one long hold-off on request so the
    // result register fills and the input side backs up, and no idling at
    // all once idle_on drops.
    initial begin : receiver
        bit hold_taken;
        hold_taken = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int sel;
        bit big_done;
        big_done = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // empty list: count 0 completes at once
        send_byte(8'd0, 1'b0);
        // one empty element with tag 0xFF; buffer end on the completing byte
        send_byte(8'd1, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'd0, 1'b1);
        // two elements: data 00 FF, then a 0xFF prefix together with buffer end
        send_byte(8'd2, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        // largest three-byte length, cut on its last prefix byte
        send_byte(8'd1, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(PFX_THREE_MAX, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // largest two-byte length, cut on its last prefix byte
        send_byte(8'd1, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(PFX_TWO_MAX, 1'b0);
        send_byte(8'hFF, 1'b1);
        // smallest three-byte length, cut after one data byte
        send_byte(8'd1, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(PFX_THREE_BASE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3C, 1'b1);

        // ---- random part ----
        idle_on = 1'b1;
        while (sent_items < RANDOM_ITEMS) begin
            if (sent_items > 80) hold_req = 1'b1;
            if (sent_items > RANDOM_ITEMS - 110) idle_on = 1'b0;
            if (!big_done && sent_items > 150) begin
                // full-size list: 255 empty elements, index up to 254
                send_list(255, 1'b0, 1'b1);
                big_done = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                // noise, resynchronized by a final buffer end
                for (int n = $urandom_range(1, 8); n > 1; n--)
                    send_byte(8'($urandom), $urandom_range(0, 9) == 0);
                send_byte(8'($urandom), 1'b1);
            end else if (sel < 15) begin
                send_list(0, 1'b0, 1'b0);
            end else if (sel < 45) begin
                send_list($urandom_range(1, 6), 1'b1, 1'b0);
            end else begin
                send_list($urandom_range(1, 4), 1'b0, 1'b0);
            end
        end
        s_valid <= 1'b0;

        // drain: outstanding is registered, so it lags the acceptance edge
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/tllpp_pkg.sv
rtl/tagged_list_length_prefix_parser_unit.sv
sim/tllpp_stream_checker.sv
sim/tb_top.sv
